FILE: rtl/core/gaze_point_blink_filter_macros.svh
// Assertion macros of the gaze point blink filter checker
`ifndef GAZE_POINT_BLINK_FILTER_MACROS_SVH
`define GAZE_POINT_BLINK_FILTER_MACROS_SVH

// same-cycle implication, ignored while in reset
`define GPBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define GPBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define GPBF_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gpbf_pkg.sv
// Types and constants of the gaze point blink filter
`timescale 1ns / 1ps
`default_nettype none

package gpbf_pkg;

  localparam int FRAC_W     = 16;
  localparam int PIX_W      = 13;
  localparam int SIZE_W     = 14;
  localparam int DZ_W       = 8;
  localparam int JL_W       = 13;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int PROD_W     = FRAC_W + SIZE_W;
  localparam int SUM_W      = PIX_W + 2;

  typedef logic [FRAC_W-1:0]     frac_t;
  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [DZ_W-1:0]       dz_t;
  typedef logic [JL_W-1:0]       jl_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_SCREEN_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_SCREEN_HEIGHT = 3'd1;
  localparam cfg_idx_t REG_DEAD_ZONE     = 3'd2;
  localparam cfg_idx_t REG_JUMP_LIMIT    = 3'd3;
  localparam cfg_idx_t REG_BLINK_HOLD    = 3'd4;

  localparam size_t RST_SCREEN_WIDTH  = 14'd1920;
  localparam size_t RST_SCREEN_HEIGHT = 14'd1080;
  localparam dz_t   RST_DEAD_ZONE     = 8'd4;
  localparam jl_t   RST_JUMP_LIMIT    = 13'd50;
  localparam cnt_t  RST_BLINK_HOLD    = 8'd10;

  // last position after reset: half of the reset screen size
  localparam pix_t RST_LAST_X = PIX_W'(RST_SCREEN_WIDTH / 2);
  localparam pix_t RST_LAST_Y = PIX_W'(RST_SCREEN_HEIGHT / 2);

  localparam pix_t PIX_MAX = {PIX_W{1'b1}};
  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    size_t screen_width;
    size_t screen_height;
    dz_t   dead_zone;
    jl_t   jump_limit;
    cnt_t  blink_hold;
  } cfg_t;

  typedef struct packed {
    logic sample_valid;
    pix_t x;
    pix_t y;
  } pix_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/gpbf_ifs.sv
// Channel interfaces of the gaze point blink filter
`timescale 1ns / 1ps
`default_nettype none

interface gpbf_in_if;
  logic            valid;
  logic            ready;
  logic            sample_valid;
  gpbf_pkg::frac_t gaze_x_frac;
  gpbf_pkg::frac_t gaze_y_frac;

  modport source (output valid, sample_valid, gaze_x_frac, gaze_y_frac, input ready);
  modport sink (input valid, sample_valid, gaze_x_frac, gaze_y_frac, output ready);
endinterface

interface gpbf_out_if;
  logic           valid;
  logic           ready;
  gpbf_pkg::pix_t point_x;
  gpbf_pkg::pix_t point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

interface gpbf_cfg_if;
  logic                valid;
  logic                ready;
  gpbf_pkg::cfg_idx_t  index;
  gpbf_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gaze_point_blink_filter.sv
// A sample beat passes the input register, the scaling multiplier register and
// the result register. Throughput: one sample beat per cycle while out_bus ready
// does not hold the pipe; each of these registers holds one beat.
// Reset (synchronous, active low): registers take their reset values, the last
// position goes to the screen center (960, 540), blink state clears, pipe empties.
// Configuration writes take effect on the next cycle; cfg ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module gaze_point_blink_filter #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  gpbf_in_if.sink           in_bus,
  gpbf_out_if.source        out_bus,
  gpbf_cfg_if.sink          cfg_bus
);
  import gpbf_pkg::*;

  cfg_t      cfg_r;
  logic      sc_valid;
  logic      sc_ready;
  pix_beat_t sc_beat;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
      cfg_r.dead_zone     <= RST_DEAD_ZONE;
      cfg_r.jump_limit    <= RST_JUMP_LIMIT;
      cfg_r.blink_hold    <= RST_BLINK_HOLD;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_bus.data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_bus.data[SIZE_W-1:0];
        REG_DEAD_ZONE:     cfg_r.dead_zone     <= cfg_bus.data[DZ_W-1:0];
        REG_JUMP_LIMIT:    cfg_r.jump_limit    <= cfg_bus.data[JL_W-1:0];
        REG_BLINK_HOLD:    cfg_r.blink_hold    <= cfg_bus.data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gpbf_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .s_valid        (in_bus.valid),
    .s_ready        (in_bus.ready),
    .s_sample_valid (in_bus.sample_valid),
    .s_x_frac       (in_bus.gaze_x_frac),
    .s_y_frac       (in_bus.gaze_y_frac),
    .screen_width   (cfg_r.screen_width),
    .screen_height  (cfg_r.screen_height),
    .m_valid        (sc_valid),
    .m_ready        (sc_ready),
    .m_beat         (sc_beat)
  );

  gpbf_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (sc_valid),
    .s_ready   (sc_ready),
    .s_beat    (sc_beat),
    .cfg       (cfg_r),
    .m_valid   (out_bus.valid),
    .m_ready   (out_bus.ready),
    .m_point_x (out_bus.point_x),
    .m_point_y (out_bus.point_y)
  );

endmodule

`default_nettype wire

FILE: rtl/core/gpbf_scale.sv
// Input register and fraction-to-pixel scaling stage
`timescale 1ns / 1ps
`default_nettype none

module gpbf_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic                s_sample_valid,
  input  gpbf_pkg::frac_t     s_x_frac,
  input  gpbf_pkg::frac_t     s_y_frac,
  input  gpbf_pkg::size_t     screen_width,
  input  gpbf_pkg::size_t     screen_height,
  output logic                m_valid,
  input  logic                m_ready,
  output gpbf_pkg::pix_beat_t m_beat
);
  import gpbf_pkg::*;

  logic      a_valid_r;
  logic      a_sv_r;
  frac_t     a_x_r;
  frac_t     a_y_r;
  logic      b_valid_r;
  pix_beat_t b_beat_r;
  pix_beat_t b_beat_nxt;
  logic      b_load;

  function automatic pix_t scale_pix(frac_t frac, size_t size);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;
    prod    = PROD_W'(frac) * PROD_W'(size);
    shifted = prod >> FRAC_BITS;
    return (|shifted[PROD_W-1:PIX_W]) ? PIX_MAX : shifted[PIX_W-1:0];
  endfunction

  assign b_load  = !b_valid_r || m_ready;
  assign s_ready = !a_valid_r || b_load;

  always_comb begin
    b_beat_nxt.sample_valid = a_sv_r;
    b_beat_nxt.x            = scale_pix(a_x_r, screen_width);
    b_beat_nxt.y            = scale_pix(a_y_r, screen_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (s_ready) begin
        a_valid_r <= s_valid;
      end
      if (b_load) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      a_sv_r <= s_sample_valid;
      a_x_r  <= s_x_frac;
      a_y_r  <= s_y_frac;
    end
    if (a_valid_r && b_load) begin
      b_beat_r <= b_beat_nxt;
    end
  end

  assign m_valid = b_valid_r;
  assign m_beat  = b_beat_r;

endmodule

`default_nettype wire

FILE: rtl/core/gpbf_track.sv
// Blink tracking, dead zone, smoothing and result register
`timescale 1ns / 1ps
`default_nettype none

module gpbf_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  gpbf_pkg::pix_beat_t s_beat,
  input  gpbf_pkg::cfg_t      cfg,
  output logic                m_valid,
  input  logic                m_ready,
  output gpbf_pkg::pix_t      m_point_x,
  output gpbf_pkg::pix_t      m_point_y
);
  import gpbf_pkg::*;

  pix_t  last_x_r, last_x_nxt;
  pix_t  last_y_r, last_y_nxt;
  logic  blink_r, blink_nxt;
  cnt_t  cnt_r, cnt_nxt;
  logic  out_valid_r;
  pix_t  out_x_r, out_y_r;

  logic  blink1;
  cnt_t  cnt1;
  pix_t  dx, dy;
  logic  still;
  logic  jump;
  logic  emit;
  logic  out_free;
  logic  take;
  logic [SUM_W-1:0] sum_x, sum_y;

  always_comb begin
    // blink timer advances first
    blink1 = blink_r;
    cnt1   = cnt_r;
    if (blink_r) begin
      if (cnt_r != CNT_MAX) begin
        cnt1 = cnt_r + 1'b1;
      end
      if (cnt1 > cfg.blink_hold) begin
        blink1 = 1'b0;
      end
    end

    dx    = (last_x_r > s_beat.x) ? last_x_r - s_beat.x : s_beat.x - last_x_r;
    dy    = (last_y_r > s_beat.y) ? last_y_r - s_beat.y : s_beat.y - last_y_r;
    still = (dx < PIX_W'(cfg.dead_zone)) && (dy < PIX_W'(cfg.dead_zone));
    jump  = !blink1 && (dy > cfg.jump_limit);

    blink_nxt  = blink1;
    cnt_nxt    = cnt1;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    emit       = 1'b0;
    if (!s_beat.sample_valid) begin
      // invalid sample starts a blink if none is running
      blink_nxt = 1'b1;
      cnt_nxt   = blink1 ? cnt1 : '0;
    end else if (!still) begin
      blink_nxt  = blink1 || jump;
      cnt_nxt    = jump ? '0 : cnt1;
      emit       = !(blink1 || jump);
      last_x_nxt = s_beat.x;
      last_y_nxt = s_beat.y;
    end

    sum_x = SUM_W'(last_x_r) + SUM_W'(s_beat.x) + {1'b0, s_beat.x, 1'b0};
    sum_y = SUM_W'(last_y_r) + SUM_W'(s_beat.y) + {1'b0, s_beat.y, 1'b0};
  end

  assign out_free = !out_valid_r || m_ready;
  assign s_ready  = !emit || out_free;
  assign take     = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= RST_LAST_X;
      last_y_r    <= RST_LAST_Y;
      blink_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        last_x_r <= last_x_nxt;
        last_y_r <= last_y_nxt;
        blink_r  <= blink_nxt;
        cnt_r    <= cnt_nxt;
      end
      if (out_free) begin
        out_valid_r <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_x_r <= sum_x[SUM_W-1:2];
      out_y_r <= sum_y[SUM_W-1:2];
    end
  end

  assign m_valid   = out_valid_r;
  assign m_point_x = out_x_r;
  assign m_point_y = out_y_r;

endmodule

`default_nettype wire

FILE: rtl/core/gpbf_checker.sv
// Port-level checker of the gaze point blink filter and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "gaze_point_blink_filter_macros.svh"

module gpbf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input gpbf_pkg::pix_t point_x,
  input gpbf_pkg::pix_t point_y,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  // pipe is empty right after reset
  `GPBF_ASSERT_RST(a_empty_after_rst, !rst_n, !out_valid, "result beat right after reset")

  // an empty result register never blocks the input side
  `GPBF_ASSERT_NOW(a_no_false_stall, !out_valid, in_ready, "input stalled with no result pending")

  // configuration writes are never refused
  `GPBF_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration beat refused")

  // a stalled result beat keeps its payload
  `GPBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(point_x) && $stable(point_y),
                    "stalled result beat changed")

endmodule

bind gaze_point_blink_filter gpbf_checker u_gpbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .point_x   (out_bus.point_x),
  .point_y   (out_bus.point_y),
  .cfg_valid (cfg_bus.valid),
  .cfg_ready (cfg_bus.ready)
);

`default_nettype wire
